### src/malt_pkg.sv
`timescale 1ns / 1ps
package malt_pkg;

  localparam logic [1:0] OP_IP   = 2'd0;
  localparam logic [1:0] OP_ARP  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_DROP   = 2'd1;
  localparam logic [1:0] VERDICT_NONE   = 2'd2;

  localparam logic [1:0] CFG_ENABLE     = 2'd0;
  localparam logic [1:0] CFG_MAX_TERM   = 2'd1;
  localparam logic [1:0] CFG_PROBE_WAIT = 2'd2;

  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int PORT_W  = 4;
  localparam int ENTRY_W = MAC_W + IP_W + IP_W + PORT_W;

  typedef struct packed {
    logic [1:0]        op;
    logic [MAC_W-1:0]  src_mac;
    logic [IP_W-1:0]   src_ip;
    logic [IP_W-1:0]   dst_ip;
    logic [PORT_W-1:0] in_port;
    logic              from_bridge;
    logic              is_udp;
  } req_t;

  typedef struct packed {
    logic [1:0]        verdict;
    logic              probe_valid;
    logic [IP_W-1:0]   probe_sender_ip;
    logic [IP_W-1:0]   probe_target_ip;
    logic [PORT_W-1:0] probe_port;
    logic              replaced;
  } rsp_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   src_ip;
    logic [IP_W-1:0]   dst_ip;
    logic [PORT_W-1:0] port;
  } entry_t;

endpackage

### src/mac_admission_limit_table.sv
`timescale 1ns / 1ps
// MAC admission limiter.
// Input channel (in_valid/in_stall/in_req) carries IP packets, ARP sightings
// and time ticks. Each request yields exactly one response on the output
// channel (out_valid/out_stall/out_rsp): a verdict and an optional ARP probe.
// An IP request scans the entry table in one RAM, one entry per cycle, newest
// first; S_EXEC then makes the verdict, S_PROBE builds any probe and
// S_OUT offers the response. ARP and tick requests go through S_READ,
// S_EXEC, S_PROBE when a probe goes out, and S_OUT. One request is in
// flight at a time; the next one is taken once the response is offered.
// Reset (rst_n low, synchronous) empties the table, ends any running check
// and restores enable=0, max_terminals=1, probe_wait_ticks=20. Table
// contents are not cleared; entries past the count are never used.
// A stalled response holds, and in_stall stays high until it is collected.
// Configuration writes (cfg_we/cfg_index/cfg_data) must be made while idle; the block does not enforce it.
module mac_admission_limit_table
  import malt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int PROBE_COUNT = 5,
  parameter int PORT_COUNT  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  req_t        in_req,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = $clog2(PROBE_COUNT + 1);
  localparam int RD = (TABLE_DEPTH > 1) ? TABLE_DEPTH : 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  req_t        req_r;
  logic        enable_r;
  logic [4:0]  max_term_r;
  logic [15:0] wait_cfg_r;
  logic [CW-1:0] count_r, count_nxt;
  logic        checking_r, checking_nxt;
  entry_t      cand_r, cand_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [PW-1:0] sent_r, sent_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic        hit_r, hit_nxt;
  rsp_t        rsp_r, rsp_nxt;
  logic        rsp_v_r, rsp_v_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  malt_ram #(.WIDTH(ENTRY_W), .DEPTH(RD)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic in_fire;
  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE) || (rsp_v_r && out_stall);
  assign out_valid = rsp_v_r;
  assign out_rsp   = rsp_r;

  logic [CW-1:0] limit;
  logic          gated;
  logic [15:0]   wait_load;
  assign limit = (32'(max_term_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(max_term_r);
  assign gated = !enable_r || !req_r.from_bridge || req_r.is_udp ||
                 (32'(req_r.in_port) >= 32'(PORT_COUNT));
  assign wait_load = wait_cfg_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    checking_nxt = checking_r;
    cand_nxt = cand_r;
    slot_nxt = slot_r;
    sent_nxt = sent_r;
    wait_nxt = wait_r;
    scan_nxt = scan_r;
    hit_nxt = hit_r;
    rsp_nxt = rsp_r;
    rsp_v_nxt = rsp_v_r && out_stall;
    ram_we = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = cand_r;
    ram_raddr = slot_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          hit_nxt = 1'b0;
          if (in_req.op == OP_IP) begin
            scan_nxt = count_r;
            state_nxt = S_SCAN;
            if (count_r != '0) begin
              ram_raddr = AW'(count_r - CW'(1));
            end
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_SCAN: begin
        if (scan_r != '0 && ram_rdata.mac == req_r.src_mac) begin
          hit_nxt = 1'b1;
        end
        if (scan_r <= CW'(1) || hit_nxt) begin
          scan_nxt = '0;
          state_nxt = S_EXEC;
        end else begin
          scan_nxt = scan_r - CW'(1);
          ram_raddr = AW'(scan_r - CW'(2));
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        rsp_nxt = '0;
        rsp_nxt.verdict = VERDICT_NONE;
        state_nxt = S_OUT;
        case (req_r.op)
          OP_IP: begin
            rsp_nxt.verdict = VERDICT_ACCEPT;
            if (!gated && !hit_r) begin
              if (count_r < limit) begin
                if (!checking_r) begin
                  ram_we = 1'b1;
                  ram_waddr = AW'(count_r);
                  ram_wdata = '{req_r.src_mac, req_r.src_ip, req_r.dst_ip,
                                req_r.in_port};
                  count_nxt = count_r + CW'(1);
                end
              end else begin
                rsp_nxt.verdict = VERDICT_DROP;
                if (!checking_r && count_r != '0) begin
                  cand_nxt = '{req_r.src_mac, req_r.src_ip, req_r.dst_ip,
                               req_r.in_port};
                  checking_nxt = 1'b1;
                  slot_nxt = AW'(count_r - CW'(1));
                  sent_nxt = '0;
                  ram_raddr = slot_nxt;
                  state_nxt = S_PROBE;
                end
              end
            end
          end
          OP_ARP: begin
            rsp_nxt.verdict = VERDICT_ACCEPT;
            if (checking_r && ram_rdata.mac == req_r.src_mac) begin
              sent_nxt = '0;
              if (slot_r == '0) begin
                checking_nxt = 1'b0;
                wait_nxt = '0;
              end else begin
                slot_nxt = slot_r - AW'(1);
                ram_raddr = slot_nxt;
                state_nxt = S_PROBE;
              end
            end
          end
          OP_TICK: begin
            if (checking_r) begin
              if (wait_r > 16'd1) begin
                wait_nxt = wait_r - 16'd1;
              end else begin
                wait_nxt = '0;
                if (32'(sent_r) < PROBE_COUNT) begin
                  state_nxt = S_PROBE;
                end else begin
                  ram_we = 1'b1;
                  rsp_nxt.replaced = 1'b1;
                  checking_nxt = 1'b0;
                  sent_nxt = '0;
                end
              end
            end
          end
          default: ;
        endcase
      end
      S_PROBE: begin
        rsp_nxt.probe_valid = 1'b1;
        rsp_nxt.probe_sender_ip = ram_rdata.src_ip;
        rsp_nxt.probe_target_ip = ram_rdata.dst_ip;
        rsp_nxt.probe_port = ram_rdata.port;
        sent_nxt = sent_r + PW'(1);
        wait_nxt = wait_load;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!rsp_v_r || !out_stall) begin
          rsp_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      enable_r <= 1'b0;
      max_term_r <= 5'd1;
      wait_cfg_r <= 16'd20;
      count_r <= '0;
      checking_r <= 1'b0;
      cand_r <= '0;
      slot_r <= '0;
      sent_r <= '0;
      wait_r <= '0;
      scan_r <= '0;
      hit_r <= 1'b0;
      rsp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      checking_r <= checking_nxt;
      cand_r <= cand_nxt;
      slot_r <= slot_nxt;
      sent_r <= sent_nxt;
      wait_r <= wait_nxt;
      scan_r <= scan_nxt;
      hit_r <= hit_nxt;
      rsp_v_r <= rsp_v_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:     enable_r <= cfg_data[0];
          CFG_MAX_TERM:   max_term_r <= cfg_data[4:0];
          CFG_PROBE_WAIT: wait_cfg_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
    if (in_fire) begin
      req_r <= in_req;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TABLE_DEPTH) else $error("entry count over depth");
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE) else $error("request not taken up");
  a_probe_checking: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> checking_r) else $error("probe without check");
  a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sent_r) <= PROBE_COUNT) else $error("too many probes");
endmodule

### src/malt_ram.sv
`timescale 1ns / 1ps
module malt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import malt_pkg::*;

  localparam int DEPTH   = 16;
  localparam int PROBES  = 5;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int REQ_W   = $bits(req_t);
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mac_admission_limit_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // limiter shadow state
  logic [MAC_W-1:0]  tbl_mac [DEPTH];
  logic [IP_W-1:0]   tbl_sip [DEPTH];
  logic [IP_W-1:0]   tbl_dip [DEPTH];
  logic [PORT_W-1:0] tbl_port[DEPTH];
  int unsigned n_entries;
  bit          probing;
  entry_t      cand;
  int unsigned slot;
  int unsigned probes_out;
  int unsigned wait_cnt;
  bit          lim_enable;
  int unsigned lim_max;
  int unsigned lim_wait;

  rsp_t verdict_q[$];
  int   errors;
  int   mismatches;
  int   n_results;
  int   n_replaced;
  int   n_probes;
  bit   idle_on;
  longint cycles;
  logic [MAC_W-1:0] mac_pool[8];

  function automatic void send_probe(inout rsp_t r);
    r.probe_valid     = 1'b1;
    r.probe_sender_ip = tbl_sip[slot];
    r.probe_target_ip = tbl_dip[slot];
    r.probe_port      = tbl_port[slot];
    probes_out++;
    wait_cnt = lim_wait;
  endfunction

  function automatic rsp_t admit_predict(req_t q);
    rsp_t r;
    int unsigned cap;
    bit known;
    r = '0;
    r.verdict = VERDICT_NONE;
    if (q.op == OP_IP) begin
      r.verdict = VERDICT_ACCEPT;
      if (lim_enable && q.from_bridge && !q.is_udp) begin
        known = 1'b0;
        for (int k = 0; k < n_entries; k++)
          if (tbl_mac[k] == q.src_mac) known = 1'b1;
        cap = (lim_max > DEPTH) ? DEPTH : lim_max;
        if (!known && n_entries < cap) begin
          if (!probing) begin
            tbl_mac[n_entries]  = q.src_mac;
            tbl_sip[n_entries]  = q.src_ip;
            tbl_dip[n_entries]  = q.dst_ip;
            tbl_port[n_entries] = q.in_port;
            n_entries++;
          end
        end else if (!known) begin
          r.verdict = VERDICT_DROP;
          if (!probing && n_entries != 0) begin
            cand = '{q.src_mac, q.src_ip, q.dst_ip, q.in_port};
            probing = 1'b1;
            slot = n_entries - 1;
            probes_out = 0;
            send_probe(r);
          end
        end
      end
    end else if (q.op == OP_ARP) begin
      r.verdict = VERDICT_ACCEPT;
      if (probing && tbl_mac[slot] == q.src_mac) begin
        probes_out = 0;
        if (slot == 0) begin
          probing = 1'b0;
          wait_cnt = 0;
        end else begin
          slot--;
          send_probe(r);
        end
      end
    end else if (q.op == OP_TICK) begin
      if (probing) begin
        if (wait_cnt > 1) wait_cnt--;
        else begin
          wait_cnt = 0;
          if (probes_out < PROBES) send_probe(r);
          else begin
            tbl_mac[slot]  = cand.mac;
            tbl_sip[slot]  = cand.src_ip;
            tbl_dip[slot]  = cand.dst_ip;
            tbl_port[slot] = cand.port;
            r.replaced = 1'b1;
            probing = 1'b0;
            probes_out = 0;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(req_t q);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_req   <= q;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdict_q.push_back(admit_predict(q));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (verdict_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected response %h", out_rsp);
      end else begin
        rsp_t e;
        e = verdict_q.pop_front();
        if (out_rsp.replaced) n_replaced++;
        if (out_rsp.probe_valid) n_probes++;
        if (out_rsp.verdict !== e.verdict || out_rsp.probe_valid !== e.probe_valid ||
            out_rsp.probe_sender_ip !== e.probe_sender_ip ||
            out_rsp.probe_target_ip !== e.probe_target_ip ||
            out_rsp.probe_port !== e.probe_port || out_rsp.replaced !== e.replaced) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected %h got %h", e, out_rsp);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout, %0d requests pending", verdict_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ENABLE) lim_enable = val[0];
    else if (idx == CFG_MAX_TERM) lim_max = val[4:0];
    else lim_wait = val[15:0];
  endtask

  function automatic req_t mk_req(logic [1:0] op, logic [MAC_W-1:0] mac);
    req_t q;
    q.op          = op;
    q.src_mac     = mac;
    q.src_ip      = $urandom();
    q.dst_ip      = $urandom();
    q.in_port     = $urandom_range(0, 15);
    q.from_bridge = 1'b1;
    q.is_udp      = 1'b0;
    return q;
  endfunction

  task automatic test_directed();
    req_t q;
    send_request(mk_req(OP_IP, 48'h1));  // disabled: accepted
    write_reg(CFG_ENABLE, 1);
    write_reg(CFG_MAX_TERM, 0);
    send_request(mk_req(OP_IP, '1));  // empty table, zero limit: drop, no check
    write_reg(CFG_MAX_TERM, 2);
    write_reg(CFG_PROBE_WAIT, 0);
    q = mk_req(OP_IP, '1);
    q.src_ip = '1; q.dst_ip = '1; q.in_port = '1;
    send_request(q);
    q = mk_req(OP_IP, 48'h0);
    q.src_ip = '0; q.dst_ip = '0; q.in_port = '0;
    send_request(q);
    send_request(mk_req(OP_IP, '1));      // known MAC
    q = mk_req(OP_IP, 48'h77); q.is_udp = 1'b1; send_request(q);
    q = mk_req(OP_IP, 48'h78); q.from_bridge = 1'b0; send_request(q);
    send_request(mk_req(OP_IP, 48'h99));  // full: check starts
    send_request(mk_req(OP_IP, 48'h9a));  // new MAC during check
    send_request(mk_req(OP_ARP, 48'h0));  // newest answers
    send_request(mk_req(OP_ARP, '1));     // oldest answers, check ends
    send_request(mk_req(OP_UNUSED, 48'h5));
    send_request(mk_req(OP_IP, 48'h99));
    repeat (6) send_request(mk_req(OP_TICK, 48'h0));  // silent entry replaced
    write_reg(CFG_MAX_TERM, 1);            // limit below count
    send_request(mk_req(OP_IP, 48'h55));
    write_reg(CFG_ENABLE, 0);
    repeat (3) send_request(mk_req(OP_TICK, 48'h0));
  endtask

  task automatic test_random(int n_items);
    req_t q;
    int sel;
    for (int i = 0; i < n_items; i++) begin
      if (i % 200 == 0) begin
        write_reg(CFG_ENABLE, $urandom_range(0, 7) != 0);
        case ($urandom_range(0, 3))
          0: write_reg(CFG_MAX_TERM, 16);
          1: write_reg(CFG_MAX_TERM, 31);
          default: write_reg(CFG_MAX_TERM, $urandom_range(0, 6));
        endcase
        case ($urandom_range(0, 3))
          0: write_reg(CFG_PROBE_WAIT, 65535);
          1: write_reg(CFG_PROBE_WAIT, 1);
          default: write_reg(CFG_PROBE_WAIT, $urandom_range(0, 4));
        endcase
        for (int k = 0; k < 8; k++) mac_pool[k] = {$urandom(), $urandom()};
        mac_pool[0] = '1;
        mac_pool[1] = '0;
      end
      if (i > n_items - 150) idle_on = 1'b0;
      sel = $urandom_range(0, 99);
      q = mk_req(OP_IP, mac_pool[$urandom_range(0, 7)]);
      if (sel < 40) begin
        q.is_udp = ($urandom_range(0, 9) == 0);
        q.from_bridge = ($urandom_range(0, 9) != 0);
      end else if (sel < 60) q.op = OP_ARP;
      else if (sel < 95) q.op = OP_TICK;
      else q = req_t'(REQ_W'({$urandom(), $urandom(), $urandom(), $urandom()}));
      if (q.op == OP_TICK && lim_wait == 65535 && probing && wait_cnt > 3)
        q.op = OP_ARP;
      if (q.op == OP_TICK && lim_wait == 65535 && !probing && sel > 90)
        q.op = OP_ARP;
      send_request(q);
    end
  endtask

  initial begin
    errors = 0; mismatches = 0; n_results = 0; n_replaced = 0; n_probes = 0;
    cycles = 0; idle_on = 1'b1;
    n_entries = 0; probing = 0; cand = '0; slot = 0; probes_out = 0; wait_cnt = 0;
    lim_enable = 0; lim_max = 1; lim_wait = 20;
    for (int k = 0; k < 8; k++) mac_pool[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1650);
    drain();
    $display("%0d responses checked, %0d probes, %0d replacements", n_results,
             n_probes, n_replaced);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### mac_admission_limit_table.f
src/malt_pkg.sv
src/malt_ram.sv
src/mac_admission_limit_table.sv
verif/testbench.sv
